FILE: hw/rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types, constants and the remainder step of the mosaic/scroll remapper.
// ----------------------------------------------------------------------------
package msr_pkg;

    // frame and mosaic size limits
    localparam logic [9:0] MAX_WIDTH   = 10'd512;
    localparam logic [8:0] MAX_HEIGHT  = 9'd256;
    localparam logic [4:0] MOSAIC_MAX  = 5'd16;

    // remainder pipeline: nine steps over three stages
    localparam int unsigned DIV_STEPS  = 3;
    localparam int unsigned DIV_STAGES = 3;

    // start-to-done pipeline depth: prep + divider stages + two finish stages
    localparam int unsigned PIPE_LATENCY = 6;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_MARGIN_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_BRIGHTNESS_NUM = 3'd3;
    localparam logic [2:0] CFG_BRIGHTNESS_DEN = 3'd4;
    localparam logic [2:0] CFG_EXTEND_TO_EDGE = 3'd5;

    // request type codes
    localparam logic REQ_COORD  = 1'b0;
    localparam logic REQ_BRIGHT = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [8:0]  dest_x;
        logic [7:0]  dest_y;
        logic [4:0]  tile_size;
        logic [9:0]  cur_scroll_x;
        logic [9:0]  snap_scroll_x;
        logic [9:0]  cur_scroll_y;
        logic [9:0]  snap_scroll_y;
        logic        track_scroll;
        logic [31:0] pixel_in;
    } msr_req_t;

    typedef struct packed {
        logic        write_enable;
        logic [8:0]  source_x;
        logic [7:0]  source_y;
        logic [31:0] pixel_out;
    } msr_result_t;

    // effective configuration, frame size already saturated
    typedef struct packed {
        logic [9:0] w;
        logic [8:0] h;
        logic [8:0] m;
        logic [3:0] num;
        logic [3:0] den;
        logic       ext;
    } msr_cfg_t;

    // one restoring-division lane: remaining dividend bits shift out at the
    // top while quotient bits shift in at the bottom
    typedef struct packed {
        logic [8:0] dq;
        logic [3:0] rem;
    } msr_lane_t;

    typedef struct packed {
        logic               req_type;
        logic               keep_px;
        logic [31:0]        pixel;
        logic               oob;
        logic               xneg;
        logic signed [10:0] xm;
        logic [7:0]         y;
        logic signed [9:0]  dx;
        logic signed [9:0]  dy;
        logic [4:0]         size;
        msr_lane_t          lane_x;
        msr_lane_t          lane_y;
        msr_lane_t [2:0]    lane_rgb;
    } msr_pipe_t;

    function automatic msr_lane_t div_step(input msr_lane_t l, input logic [4:0] d);
        msr_lane_t  r;
        logic [4:0] t;
        logic [4:0] nr;
        logic       ge;
        t     = {l.rem, l.dq[8]};
        ge    = (t >= d);
        nr    = ge ? (t - d) : t;
        r.rem = nr[3:0];
        r.dq  = {l.dq[7:0], ge};
        return r;
    endfunction

endpackage

FILE: hw/rtl/msr_prep.sv
// ----------------------------------------------------------------------------
// msr_prep
// Entry stage: scroll deltas, bounds test, grid offset, channel products.
// ----------------------------------------------------------------------------
module msr_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  msr_pkg::msr_req_t in_req,
    input  msr_pkg::msr_cfg_t cfg,
    output logic              out_valid,
    output msr_pkg::msr_pipe_t out_pipe
);
    import msr_pkg::*;

    logic               valid_reg;
    msr_pipe_t          pipe_reg;
    msr_pipe_t          pipe_next;

    logic [9:0]         dx_raw;
    logic [9:0]         dy_raw;
    logic signed [9:0]  dx;
    logic signed [9:0]  dy;
    logic signed [10:0] bx;
    logic signed [10:0] by;
    logic signed [10:0] xm;
    logic signed [10:0] xm_neg;
    logic [4:0]         size_sat;
    logic [11:0]        prod [3];

    always_comb
    begin
        dx_raw = in_req.cur_scroll_x - in_req.snap_scroll_x;
        dy_raw = in_req.cur_scroll_y - in_req.snap_scroll_y;
        dx     = in_req.track_scroll ? signed'(dx_raw) : '0;
        dy     = in_req.track_scroll ? signed'(dy_raw) : '0;
        bx     = signed'({2'b00, in_req.dest_x}) + signed'({dx[9], dx});
        by     = signed'({3'b000, in_req.dest_y}) + signed'({dy[9], dy});
        xm     = signed'({2'b00, in_req.dest_x}) - signed'({2'b00, cfg.m});
        xm_neg = -xm;

        if (in_req.tile_size == 5'd0)
        begin
            size_sat = 5'd1;
        end
        else if (in_req.tile_size > MOSAIC_MAX)
        begin
            size_sat = MOSAIC_MAX;
        end
        else
        begin
            size_sat = in_req.tile_size;
        end

        for (int i = 0; i < 3; i++)
        begin
            prod[i] = {4'b0000, in_req.pixel_in[8*i +: 8]} * {8'h00, cfg.num};
        end

        pipe_next.req_type = in_req.req_type;
        pipe_next.keep_px  = (cfg.den == 4'd0) || (cfg.num >= cfg.den);
        pipe_next.pixel    = in_req.pixel_in;
        pipe_next.oob      = !cfg.ext && (bx[10] || by[10]
                             || (bx >= signed'({1'b0, cfg.w}))
                             || (by >= signed'({2'b00, cfg.h})));
        pipe_next.xneg     = xm[10];
        pipe_next.xm       = xm;
        pipe_next.y        = in_req.dest_y;
        pipe_next.dx       = dx;
        pipe_next.dy       = dy;
        pipe_next.size     = size_sat;
        pipe_next.lane_x.dq  = xm[10] ? xm_neg[8:0] : xm[8:0];
        pipe_next.lane_x.rem = '0;
        pipe_next.lane_y.dq  = {1'b0, in_req.dest_y};
        pipe_next.lane_y.rem = '0;
        // top three product bits start as the partial remainder; they stay
        // below den whenever scaling applies
        for (int i = 0; i < 3; i++)
        begin
            pipe_next.lane_rgb[i].dq  = prod[i][8:0];
            pipe_next.lane_rgb[i].rem = {1'b0, prod[i][11:9]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_reg <= pipe_next;
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

FILE: hw/rtl/msr_div_stage.sv
// ----------------------------------------------------------------------------
// msr_div_stage
// One register stage of the restoring remainder/quotient pipeline.
// ----------------------------------------------------------------------------
module msr_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  msr_pkg::msr_pipe_t in_pipe,
    input  logic [3:0]         den,
    output logic               out_valid,
    output msr_pkg::msr_pipe_t out_pipe
);
    import msr_pkg::*;

    logic      valid_reg;
    msr_pipe_t pipe_reg;
    msr_pipe_t pipe_next;

    // coordinate lanes divide by the mosaic size, color lanes by den
    always_comb
    begin
        pipe_next = in_pipe;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            pipe_next.lane_x = div_step(pipe_next.lane_x, pipe_next.size);
            pipe_next.lane_y = div_step(pipe_next.lane_y, pipe_next.size);
            for (int i = 0; i < 3; i++)
            begin
                pipe_next.lane_rgb[i] = div_step(pipe_next.lane_rgb[i], {1'b0, den});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_reg <= pipe_next;
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

FILE: hw/rtl/msr_finish.sv
// ----------------------------------------------------------------------------
// msr_finish
// Grid floor, delta add, clamp and result formatting (two stages).
// ----------------------------------------------------------------------------
module msr_finish (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  msr_pkg::msr_pipe_t   in_pipe,
    input  msr_pkg::msr_cfg_t    cfg,
    output logic                 out_valid,
    output msr_pkg::msr_result_t out_result
);
    import msr_pkg::*;

    // stage A: sums
    logic               a_valid_reg;
    logic               a_req_reg;
    logic               a_oob_reg;
    logic signed [11:0] a_sumx_reg;
    logic signed [10:0] a_sumy_reg;
    logic [31:0]        a_pixel_reg;

    logic [4:0]         radj;
    logic signed [11:0] gx;
    logic [7:0]         gy;
    logic signed [11:0] sumx_next;
    logic signed [10:0] sumy_next;
    logic [31:0]        pixel_next;

    // stage B: output
    logic               valid_reg;
    msr_result_t        result_reg;
    msr_result_t        result_next;
    logic [9:0]         w_m1;
    logic [8:0]         h_m1;
    logic [8:0]         sx;
    logic [7:0]         sy;

    always_comb
    begin
        // floor for negative offsets: step down by size - rem unless exact
        if (in_pipe.xneg)
        begin
            radj = (in_pipe.lane_x.rem == 4'd0) ? 5'd0
                 : (in_pipe.size - {1'b0, in_pipe.lane_x.rem});
        end
        else
        begin
            radj = {1'b0, in_pipe.lane_x.rem};
        end
        gx        = signed'({in_pipe.xm[10], in_pipe.xm}) - signed'({7'd0, radj});
        sumx_next = gx + signed'({3'b000, cfg.m}) + signed'({{2{in_pipe.dx[9]}}, in_pipe.dx});
        gy        = in_pipe.y - {4'h0, in_pipe.lane_y.rem};
        sumy_next = signed'({3'b000, gy}) + signed'({in_pipe.dy[9], in_pipe.dy});

        if (in_pipe.keep_px)
        begin
            pixel_next = in_pipe.pixel;
        end
        else
        begin
            pixel_next = {in_pipe.pixel[31:24], in_pipe.lane_rgb[2].dq[7:0],
                          in_pipe.lane_rgb[1].dq[7:0], in_pipe.lane_rgb[0].dq[7:0]};
        end
    end

    always_comb
    begin
        w_m1 = cfg.w - 10'd1;
        h_m1 = cfg.h - 9'd1;

        if (a_sumx_reg[11])
        begin
            sx = '0;
        end
        else if (a_sumx_reg[10:0] >= {1'b0, cfg.w})
        begin
            sx = w_m1[8:0];
        end
        else
        begin
            sx = a_sumx_reg[8:0];
        end

        if (a_sumy_reg[10])
        begin
            sy = '0;
        end
        else if (a_sumy_reg[9:0] >= {1'b0, cfg.h})
        begin
            sy = h_m1[7:0];
        end
        else
        begin
            sy = a_sumy_reg[7:0];
        end

        result_next = '0;
        if (a_req_reg == REQ_BRIGHT)
        begin
            result_next.pixel_out = a_pixel_reg;
        end
        else if (!a_oob_reg)
        begin
            result_next.write_enable = 1'b1;
            result_next.source_x     = sx;
            result_next.source_y     = sy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            valid_reg   <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_req_reg   <= in_pipe.req_type;
        a_oob_reg   <= in_pipe.oob;
        a_sumx_reg  <= sumx_next;
        a_sumy_reg  <= sumy_next;
        a_pixel_reg <= pixel_next;
        result_reg  <= result_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

FILE: hw/rtl/mosaic_scroll_pixel_remap_core.sv
// ----------------------------------------------------------------------------
// mosaic_scroll_pixel_remap_core
// Maps destination pixels to saved-frame fetch positions and scales pixels.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                            Transfer
//  -------   --------------------------------   -------------------------------
//  request   start, busy, req (msr_req_t)       taken when start && !busy
//  result    done, result (msr_result_t)        valid for the one cycle done=1
//  config    cfg_we, cfg_index, cfg_data        written when cfg_we=1
//
//  One request per clock, every clock; busy is always low.
//  From start to done a request passes the entry stage, three remainder stages
//  (nine restoring steps, three per stage, for the mosaic grid and the
//  brightness divide), then floor/add and clamp/format stages.
//  Reset clears all valid bits and loads the configuration defaults.
//  The receiver cannot stall, so the pipeline never holds; done pulses once
//  per request in request order.
//
module mosaic_scroll_pixel_remap_core (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 start,
    output logic                 busy,
    input  msr_pkg::msr_req_t    req,
    // result channel
    output logic                 done,
    output msr_pkg::msr_result_t result,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [9:0]           cfg_data
);
    import msr_pkg::*;

    // configuration registers
    logic [9:0] frame_width_reg;
    logic [8:0] frame_height_reg;
    logic [8:0] margin_width_reg;
    logic [3:0] brightness_num_reg;
    logic [3:0] brightness_den_reg;
    logic       extend_to_edge_reg;

    msr_cfg_t   cfg;

    // pipeline links: entry stage, then one per remainder stage
    logic       stage_valid [DIV_STAGES+1];
    msr_pipe_t  stage_pipe  [DIV_STAGES+1];

    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= 10'd256;
            frame_height_reg   <= 9'd224;
            margin_width_reg   <= 9'd64;
            brightness_num_reg <= 4'd15;
            brightness_den_reg <= 4'd15;
            extend_to_edge_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data;
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[8:0];
                CFG_MARGIN_WIDTH:   margin_width_reg   <= cfg_data[8:0];
                CFG_BRIGHTNESS_NUM: brightness_num_reg <= cfg_data[3:0];
                CFG_BRIGHTNESS_DEN: brightness_den_reg <= cfg_data[3:0];
                CFG_EXTEND_TO_EDGE: extend_to_edge_reg <= cfg_data[0];
                default:            ;  // unused indexes are ignored
            endcase
        end
    end

    // effective frame size: zero counts as one, oversize saturates
    always_comb
    begin
        if (frame_width_reg == 10'd0)
        begin
            cfg.w = 10'd1;
        end
        else if (frame_width_reg > MAX_WIDTH)
        begin
            cfg.w = MAX_WIDTH;
        end
        else
        begin
            cfg.w = frame_width_reg;
        end

        if (frame_height_reg == 9'd0)
        begin
            cfg.h = 9'd1;
        end
        else if (frame_height_reg > MAX_HEIGHT)
        begin
            cfg.h = MAX_HEIGHT;
        end
        else
        begin
            cfg.h = frame_height_reg;
        end

        cfg.m   = margin_width_reg;
        cfg.num = brightness_num_reg;
        cfg.den = brightness_den_reg;
        cfg.ext = extend_to_edge_reg;
    end

    // fully pipelined, so a request is always taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    msr_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_req    (req),
        .cfg       (cfg),
        .out_valid (stage_valid[0]),
        .out_pipe  (stage_pipe[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        msr_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_pipe   (stage_pipe[g]),
            .den       (cfg.den),
            .out_valid (stage_valid[g+1]),
            .out_pipe  (stage_pipe[g+1])
        );
    end

    msr_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stage_valid[DIV_STAGES]),
        .in_pipe    (stage_pipe[DIV_STAGES]),
        .cfg        (cfg),
        .out_valid  (done),
        .out_result (result)
    );

endmodule

FILE: hw/rtl/msr_checker.sv
// ----------------------------------------------------------------------------
// msr_checker
// Port-level timing and result-format checks for the remap core.
// ----------------------------------------------------------------------------
module msr_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input msr_pkg::msr_req_t    req,
    input logic                 done,
    input msr_pkg::msr_result_t result
);
    import msr_pkg::*;

    // every taken request yields exactly one result after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("request without result");

    a_latency_rev: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without request");

    // coordinate results carry no pixel
    a_coord_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(req.req_type, PIPE_LATENCY) == REQ_COORD)
        |-> (result.pixel_out == 32'd0))
        else $error("coordinate result with pixel data");

    // brightness results carry no write and keep alpha
    a_bright_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(req.req_type, PIPE_LATENCY) == REQ_BRIGHT)
        |-> (!result.write_enable && result.source_x == 9'd0
             && result.source_y == 8'd0
             && result.pixel_out[31:24] == $past(req.pixel_in[31:24], PIPE_LATENCY)))
        else $error("bad brightness result");

endmodule

bind mosaic_scroll_pixel_remap_core msr_checker u_msr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);

FILE: sim/msr_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_result_checker
// Watches the request, result and register channels of the remapper,
// predicts each result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module msr_result_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  msr_pkg::msr_req_t    req,
    input  logic                 done,
    input  msr_pkg::msr_result_t result,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [9:0]           cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   compared
);
    import msr_pkg::*;

    // shadow copy of the register file
    logic [9:0] frame_w;
    logic [8:0] frame_h;
    logic [8:0] margin;
    logic [3:0] bright_num;
    logic [3:0] bright_den;
    logic       extend_edge;

    msr_result_t expected_q [$];
    msr_result_t want;

    // scroll difference wrapped into -512..511
    function automatic int scroll_delta(input logic [9:0] cur, input logic [9:0] saved);
        logic [9:0] d;
        d = cur - saved;
        return (d >= 10'd512) ? int'(d) - 1024 : int'(d);
    endfunction

    // round down to the mosaic grid, floor for negative positions
    function automatic int snap_to_grid(input int c, input int size);
        if (size <= 1)
            return c;
        if (c >= 0)
            return c - c % size;
        return c - (size - (-c) % size) % size;
    endfunction

    function automatic int clamp_to_span(input int v, input int span);
        if (v < 0)
            return 0;
        return (v >= span) ? span - 1 : v;
    endfunction

    function automatic msr_result_t remap_pixel(input msr_req_t r);
        msr_result_t o;
        int size;
        int w;
        int h;
        int m;
        int dx;
        int dy;
        int sx;
        int sy;
        int ch_r;
        int ch_g;
        int ch_b;
        o = '0;
        if (r.req_type == REQ_BRIGHT)
        begin
            if (bright_den == 4'd0 || bright_num >= bright_den)
                o.pixel_out = r.pixel_in;
            else
            begin
                ch_r = int'(r.pixel_in[23:16]) * int'(bright_num) / int'(bright_den);
                ch_g = int'(r.pixel_in[15:8]) * int'(bright_num) / int'(bright_den);
                ch_b = int'(r.pixel_in[7:0]) * int'(bright_num) / int'(bright_den);
                o.pixel_out = {r.pixel_in[31:24], ch_r[7:0], ch_g[7:0], ch_b[7:0]};
            end
            return o;
        end
        size = int'(r.tile_size);
        if (size < 1)
            size = 1;
        if (size > int'(MOSAIC_MAX))
            size = int'(MOSAIC_MAX);
        w = int'(frame_w);
        if (w < 1)
            w = 1;
        if (w > int'(MAX_WIDTH))
            w = int'(MAX_WIDTH);
        h = int'(frame_h);
        if (h < 1)
            h = 1;
        if (h > int'(MAX_HEIGHT))
            h = int'(MAX_HEIGHT);
        m = int'(margin);
        dx = 0;
        dy = 0;
        if (r.track_scroll)
        begin
            dx = scroll_delta(r.cur_scroll_x, r.snap_scroll_x);
            dy = scroll_delta(r.cur_scroll_y, r.snap_scroll_y);
        end
        // shifted position off the frame: no write unless edge extension
        if (!extend_edge && (int'(r.dest_x) + dx < 0 || int'(r.dest_y) + dy < 0 ||
                             int'(r.dest_x) + dx >= w || int'(r.dest_y) + dy >= h))
            return o;
        sx = clamp_to_span(snap_to_grid(int'(r.dest_x) - m, size) + m + dx, w);
        sy = clamp_to_span(snap_to_grid(int'(r.dest_y), size) + dy, h);
        o.write_enable = 1'b1;
        o.source_x     = sx[8:0];
        o.source_y     = sy[7:0];
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w     = 10'd256;
            frame_h     = 9'd224;
            margin      = 9'd64;
            bright_num  = 4'd15;
            bright_den  = 4'd15;
            extend_edge = 1'b0;
            expected_q.delete();
            mismatches  = 0;
            outstanding = 0;
            compared    = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("write_enable", 32'(want.write_enable),
                                32'(result.write_enable));
                    check_field("source_x", 32'(want.source_x), 32'(result.source_x));
                    check_field("source_y", 32'(want.source_y), 32'(result.source_y));
                    check_field("pixel_out", want.pixel_out, result.pixel_out);
                    compared++;
                end
            end
            // predict with the settings in force before any write at this edge
            if (start && !busy)
                expected_q.push_back(remap_pixel(req));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:    frame_w     = cfg_data[9:0];
                    CFG_FRAME_HEIGHT:   frame_h     = cfg_data[8:0];
                    CFG_MARGIN_WIDTH:   margin      = cfg_data[8:0];
                    CFG_BRIGHTNESS_NUM: bright_num  = cfg_data[3:0];
                    CFG_BRIGHTNESS_DEN: bright_den  = cfg_data[3:0];
                    CFG_EXTEND_TO_EDGE: extend_edge = cfg_data[0];
                    default: ;
                endcase
            end
            outstanding = expected_q.size();
        end
    end

endmodule

FILE: sim/mosaic_scroll_pixel_remap_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mosaic_scroll_pixel_remap_core_test
// Drives coordinate and brightness requests through the remapper under a
// series of register settings, with random gaps between requests; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module mosaic_scroll_pixel_remap_core_test;
    import msr_pkg::*;

    localparam int CLK_HALF        = 6;       // 12 ns period
    localparam int RESET_CYCLES    = 9;
    localparam int PHASES          = 10;      // register settings after reset
    localparam int FIXED_PHASES    = 6;       // hand-picked settings, rest random
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PRESSURE_PHASE  = 3;       // phase with a mid-phase drain
    // worst case is ~1100 requests with random gaps; keep a wide margin
    localparam int CYCLE_LIMIT     = 300000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    msr_req_t    req;
    logic        done;
    msr_result_t result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [9:0]  cfg_data;

    // from the checker
    int mismatches;
    int outstanding;
    int compared;

    int cycle_count = 0;
    int coord_sent;
    int bright_sent;
    int settings_applied;
    bit idle_on;
    // saturated frame size in force, to aim most positions inside the frame
    int eff_w;
    int eff_h;

    // hand-picked settings: extremes of every register
    //   0: largest frame, zero margin, black-out scaling, edge extension
    //   1: smallest frame, zero denominator
    //   2: zero frame size (saturates up), widest margin, num above den
    //   3: oversized frame (saturates down), num 1 of 15
    //   4: reset geometry with half brightness
    //   5: odd sizes, edge extension
    int set_w   [FIXED_PHASES] = '{512, 1,   0,  1023, 256, 300};
    int set_h   [FIXED_PHASES] = '{256, 1,   0,  511,  224, 200};
    int set_m   [FIXED_PHASES] = '{0,   1,   511, 256, 64,  33};
    int set_num [FIXED_PHASES] = '{0,   7,   15, 1,    8,   5};
    int set_den [FIXED_PHASES] = '{15,  0,   14, 15,   15,  9};
    int set_ext [FIXED_PHASES] = '{1,   0,   1,  1,    0,   1};

    mosaic_scroll_pixel_remap_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    msr_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // watchdog: a lost result or a stuck busy ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mosaic_scroll_pixel_remap_core_test: done, errors");
            $finish;
        end
    end

    // Register write; called right after a falling edge, returns after the next.
    task automatic set_reg(input logic [2:0] idx, input int unsigned value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[9:0];
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_setting(input int w, input int h, input int m,
                                 input int num, input int den, input int ext);
        set_reg(CFG_FRAME_WIDTH, w);
        set_reg(CFG_FRAME_HEIGHT, h);
        set_reg(CFG_MARGIN_WIDTH, m);
        set_reg(CFG_BRIGHTNESS_NUM, num);
        set_reg(CFG_BRIGHTNESS_DEN, den);
        set_reg(CFG_EXTEND_TO_EDGE, ext);
        eff_w = (w < 1) ? 1 : ((w > 512) ? 512 : w);
        eff_h = (h < 1) ? 1 : ((h > 256) ? 256 : h);
        settings_applied++;
    endtask

    // Offer one request and hold it until taken. start stays high afterwards
    // so back-to-back requests need no toggle; a random gap drops it.
    task automatic issue_request(input msr_req_t item);
        start = 1'b1;
        req   = item;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
        if (item.req_type == REQ_BRIGHT)
            bright_sent++;
        else
            coord_sent++;
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // stop offering requests and wait until every result has been seen
    task automatic wait_drained();
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic msr_req_t coord_req(input int x, input int y, input int size,
                                           input int cx, input int sx, input int cy,
                                           input int sy, input bit track);
        msr_req_t r;
        r = '0;
        r.req_type      = REQ_COORD;
        r.dest_x        = x[8:0];
        r.dest_y        = y[7:0];
        r.tile_size     = size[4:0];
        r.cur_scroll_x  = cx[9:0];
        r.snap_scroll_x = sx[9:0];
        r.cur_scroll_y  = cy[9:0];
        r.snap_scroll_y = sy[9:0];
        r.track_scroll  = track;
        r.pixel_in      = $urandom();   // ignored by coordinate requests
        return r;
    endfunction

    function automatic msr_req_t bright_req(input logic [31:0] pixel);
        msr_req_t r;
        r = '0;
        r.req_type = REQ_BRIGHT;
        r.pixel_in = pixel;
        return r;
    endfunction

    // Mostly well-formed requests: positions aimed inside the frame, scroll
    // pairs close together so the shift keeps the pixel on screen; one in
    // ten is raw noise over all 96 bits.
    function automatic msr_req_t random_request();
        msr_req_t r;
        int pick;
        int off;
        if ($urandom_range(0, 9) == 0)
        begin
            r = {$urandom(), $urandom(), $urandom()};
            return r;
        end
        r = '0;
        r.req_type = ($urandom_range(0, 9) < 3) ? REQ_BRIGHT : REQ_COORD;
        r.dest_x = ($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 511))
                                               : 9'($urandom_range(0, eff_w - 1));
        r.dest_y = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, eff_h - 1));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            r.tile_size = 5'd0;                          // taken as 1
        else if (pick == 1)
            r.tile_size = 5'($urandom_range(17, 31));    // saturates to 16
        else
            r.tile_size = 5'($urandom_range(1, 16));
        r.cur_scroll_x = 10'($urandom_range(0, 1023));
        r.cur_scroll_y = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 2) == 0)
        begin
            r.snap_scroll_x = 10'($urandom_range(0, 1023));
            r.snap_scroll_y = 10'($urandom_range(0, 1023));
        end
        else
        begin
            off = $urandom_range(0, 48) - 24;
            r.snap_scroll_x = 10'(int'(r.cur_scroll_x) + off);
            off = $urandom_range(0, 48) - 24;
            r.snap_scroll_y = 10'(int'(r.cur_scroll_y) + off);
        end
        r.track_scroll = ($urandom_range(0, 3) != 0);
        r.pixel_in     = $urandom();
        return r;
    endfunction

    initial
    begin
        int phase;
        int n;
        rst_n            = 1'b0;
        start            = 1'b0;
        req              = '0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_FRAME_WIDTH;
        cfg_data         = '0;
        idle_on          = 1'b1;
        eff_w            = 256;
        eff_h            = 224;
        coord_sent       = 0;
        bright_sent      = 0;
        settings_applied = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed requests under the reset settings ----
        // origin, no mosaic, no tracking
        issue_request(coord_req(0, 0, 1, 0, 0, 0, 0, 1'b0));
        // far corner: x beyond a 256-wide frame, so no write
        issue_request(coord_req(511, 255, 16, 0, 0, 0, 0, 1'b0));
        // last pixel inside the frame, largest mosaic
        issue_request(coord_req(255, 223, 16, 0, 0, 0, 0, 1'b0));
        // mosaic size zero and oversized
        issue_request(coord_req(10, 20, 0, 0, 0, 0, 0, 1'b0));
        issue_request(coord_req(100, 100, 31, 0, 0, 0, 0, 1'b0));
        // left of the margin: grid floor below zero
        issue_request(coord_req(3, 5, 5, 0, 0, 0, 0, 1'b0));
        // scroll wrap by one in each direction
        issue_request(coord_req(100, 100, 4, 0, 1023, 1023, 0, 1'b1));
        // wrap extremes: -512 and +511 push the pixel out
        issue_request(coord_req(100, 100, 1, 512, 0, 0, 0, 1'b1));
        issue_request(coord_req(0, 10, 1, 511, 0, 0, 0, 1'b1));
        // negative shift leaves the frame at the top
        issue_request(coord_req(20, 0, 1, 0, 0, 0, 7, 1'b1));
        // large scroll difference ignored while tracking is off
        issue_request(coord_req(50, 50, 3, 700, 5, 1023, 2, 1'b0));
        // brightness at num == den: pixels pass unchanged
        issue_request(bright_req(32'hffff_ffff));
        issue_request(bright_req(32'h0000_0000));
        issue_request(bright_req(32'h1234_5678));
        wait_drained();

        // ---- register settings, each followed by random traffic ----
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < FIXED_PHASES)
                apply_setting(set_w[phase], set_h[phase], set_m[phase],
                              set_num[phase], set_den[phase], set_ext[phase]);
            else
                apply_setting($urandom_range(0, 1023), $urandom_range(0, 511),
                              $urandom_range(0, 511), $urandom_range(0, 15),
                              $urandom_range(0, 15), $urandom_range(0, 1));
            // the closing phase runs back to back
            idle_on = (phase != PHASES - 1);
            if (phase == 0)
            begin
                // edge extension on: shifted past both sides, clamped
                issue_request(coord_req(0, 0, 1, 0, 3, 0, 3, 1'b1));
                issue_request(coord_req(511, 255, 1, 3, 0, 3, 0, 1'b1));
                // scaling to black
                issue_request(bright_req(32'h80ff_ffff));
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // hold the sender until the pipeline has emptied once
                if (phase == PRESSURE_PHASE && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                issue_request(random_request());
            end
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (PIPE_LATENCY + 4) @(negedge clk);

        $display("run covered %0d requests (%0d coordinate, %0d brightness) over %0d settings",
                 coord_sent + bright_sent, coord_sent, bright_sent, settings_applied + 1);
        $display("%0d results compared, %0d field mismatches", compared, mismatches);
        if (mismatches == 0)
            $display("mosaic_scroll_pixel_remap_core_test: done, clean");
        else
            $display("mosaic_scroll_pixel_remap_core_test: done, errors");
        $finish;
    end

endmodule
